### rtl/collider_pair_overlap_test_unit_macros.svh
// assertion helpers shared by the collider pair overlap test unit
// both macros expect signals named clk and arst_n in the calling scope
`ifndef COLLIDER_PAIR_OVERLAP_TEST_UNIT_MACROS_SVH
`define COLLIDER_PAIR_OVERLAP_TEST_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CPOT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("collider pair overlap check failed");
`define CPOT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("collider pair overlap check failed");
`else
`define CPOT_ASSERT_IMPL(label, ante, cons)
`define CPOT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/cpot_pkg.sv
package cpot_pkg;

	localparam int CoordBitsDef = 16;
	localparam int LayerBitsDef = 16;
	localparam int CenterW      = 48;
	localparam int ExtentW      = 48;
	localparam int LayerW       = 16;
	localparam int Lanes        = 3;

	typedef enum logic {
		SHAPE_SPHERE = 1'b0,
		SHAPE_BOX    = 1'b1
	} shape_t;

	// per-beat control that rides along the pipeline
	typedef struct packed {
		logic pass;
		logic box_box;
	} ctl_t;

endpackage

### rtl/cpot_pair_if.sv
interface cpot_pair_if;
	logic                            valid;
	logic                            ready;
	cpot_pkg::shape_t                first_shape;
	logic [cpot_pkg::CenterW-1:0]    first_center;
	logic [cpot_pkg::ExtentW-1:0]    first_extent;
	logic [cpot_pkg::LayerW-1:0]     first_layer;
	logic [cpot_pkg::LayerW-1:0]     first_mask;
	cpot_pkg::shape_t                second_shape;
	logic [cpot_pkg::CenterW-1:0]    second_center;
	logic [cpot_pkg::ExtentW-1:0]    second_extent;
	logic [cpot_pkg::LayerW-1:0]     second_layer;
	logic [cpot_pkg::LayerW-1:0]     second_mask;

	modport source (
		output valid, first_shape, first_center, first_extent, first_layer, first_mask,
		output second_shape, second_center, second_extent, second_layer, second_mask,
		input  ready
	);
	modport sink (
		input  valid, first_shape, first_center, first_extent, first_layer, first_mask,
		input  second_shape, second_center, second_extent, second_layer, second_mask,
		output ready
	);
endinterface

### rtl/cpot_result_if.sv
interface cpot_result_if;
	logic valid;
	logic ready;
	logic overlap;
	logic filter_pass;

	modport source (output valid, overlap, filter_pass, input ready);
	modport sink (input valid, overlap, filter_pass, output ready);
endinterface

### rtl/cpot_prep.sv
module cpot_prep #(
	parameter int COORD_BITS = cpot_pkg::CoordBitsDef,
	parameter int LAYER_BITS = cpot_pkg::LayerBitsDef
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  cpot_pkg::shape_t                            first_shape,
	input  logic [cpot_pkg::CenterW-1:0]                first_center,
	input  logic [cpot_pkg::ExtentW-1:0]                first_extent,
	input  logic [cpot_pkg::LayerW-1:0]                 first_layer,
	input  logic [cpot_pkg::LayerW-1:0]                 first_mask,
	input  cpot_pkg::shape_t                            second_shape,
	input  logic [cpot_pkg::CenterW-1:0]                second_center,
	input  logic [cpot_pkg::ExtentW-1:0]                second_extent,
	input  logic [cpot_pkg::LayerW-1:0]                 second_layer,
	input  logic [cpot_pkg::LayerW-1:0]                 second_mask,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output cpot_pkg::ctl_t                              ctl,
	output logic [cpot_pkg::Lanes-1:0][COORD_BITS:0]    delta,
	output logic [cpot_pkg::Lanes-1:0][COORD_BITS:0]    ext,
	output logic [COORD_BITS:0]                         radius
);

	localparam int PackW = cpot_pkg::Lanes * COORD_BITS;
	localparam logic [cpot_pkg::LayerW-1:0] LayerMask =
		cpot_pkg::LayerW'((64'd1 << LAYER_BITS) - 64'd1);

	logic [PackW-1:0]                          fc_w, sc_w, fe_w, se_w;
	logic [cpot_pkg::Lanes-1:0][COORD_BITS:0]  ca, cb, ea, eb;
	logic [cpot_pkg::Lanes-1:0][COORD_BITS:0]  delta_d, ext_d;
	logic [COORD_BITS:0]                       radius_d;
	logic                                      sph_first, sph_second, box_box, both_sph;
	cpot_pkg::ctl_t                            ctl_d;

	logic                                      v_s1;
	cpot_pkg::ctl_t                            ctl_s1;
	logic [cpot_pkg::Lanes-1:0][COORD_BITS:0]  delta_s1, ext_s1;
	logic [COORD_BITS:0]                       radius_s1;

	// lanes past the 48-bit field read as zero
	assign fc_w = PackW'({{PackW{1'b0}}, first_center});
	assign sc_w = PackW'({{PackW{1'b0}}, second_center});
	assign fe_w = PackW'({{PackW{1'b0}}, first_extent});
	assign se_w = PackW'({{PackW{1'b0}}, second_extent});

	assign sph_first  = (first_shape == cpot_pkg::SHAPE_SPHERE);
	assign sph_second = (second_shape == cpot_pkg::SHAPE_SPHERE);
	assign box_box    = !sph_first && !sph_second;
	assign both_sph   = sph_first && sph_second;

	always_comb begin
		for (int i = 0; i < cpot_pkg::Lanes; i++) begin
			ca[i] = {fc_w[i*COORD_BITS+COORD_BITS-1], fc_w[i*COORD_BITS +: COORD_BITS]};
			cb[i] = {sc_w[i*COORD_BITS+COORD_BITS-1], sc_w[i*COORD_BITS +: COORD_BITS]};
			ea[i] = {1'b0, fe_w[i*COORD_BITS +: COORD_BITS]};
			eb[i] = {1'b0, se_w[i*COORD_BITS +: COORD_BITS]};
			// sphere center minus box center; box pairs grow one box by the other
			if (sph_first || box_box) begin
				delta_d[i] = ca[i] - cb[i];
			end else begin
				delta_d[i] = cb[i] - ca[i];
			end
			if (box_box) begin
				ext_d[i] = ea[i] + eb[i];
			end else if (both_sph) begin
				ext_d[i] = '0;
			end else if (sph_first) begin
				ext_d[i] = eb[i];
			end else begin
				ext_d[i] = ea[i];
			end
		end
		if (both_sph) begin
			radius_d = ea[0] + eb[0];
		end else if (box_box) begin
			radius_d = '0;
		end else if (sph_first) begin
			radius_d = ea[0];
		end else begin
			radius_d = eb[0];
		end
		ctl_d.pass    = (|(first_mask & second_layer & LayerMask)) &&
		                (|(second_mask & first_layer & LayerMask));
		ctl_d.box_box = box_box;
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctl_s1    <= ctl_d;
			delta_s1  <= delta_d;
			ext_s1    <= ext_d;
			radius_s1 <= radius_d;
		end
	end

	assign out_valid = v_s1;
	assign ctl       = ctl_s1;
	assign delta     = delta_s1;
	assign ext       = ext_s1;
	assign radius    = radius_s1;

endmodule

### rtl/cpot_clamp.sv
module cpot_clamp #(
	parameter int COORD_BITS = cpot_pkg::CoordBitsDef
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  cpot_pkg::ctl_t                              in_ctl,
	input  logic [cpot_pkg::Lanes-1:0][COORD_BITS:0]    delta,
	input  logic [cpot_pkg::Lanes-1:0][COORD_BITS:0]    ext,
	input  logic [COORD_BITS:0]                         in_radius,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output cpot_pkg::ctl_t                              out_ctl,
	output logic [cpot_pkg::Lanes-1:0][COORD_BITS-1:0]  gap,
	output logic [COORD_BITS:0]                         out_radius
);

	logic [cpot_pkg::Lanes-1:0][COORD_BITS:0]    neg, mag;
	logic [cpot_pkg::Lanes-1:0][COORD_BITS-1:0]  gap_d;

	logic                                        v_s2;
	cpot_pkg::ctl_t                              ctl_s2;
	logic [cpot_pkg::Lanes-1:0][COORD_BITS-1:0]  gap_s2;
	logic [COORD_BITS:0]                         radius_s2;

	// distance from the point to the interval [-ext, ext], zero inside
	always_comb begin
		for (int i = 0; i < cpot_pkg::Lanes; i++) begin
			neg[i] = -delta[i];
			mag[i] = delta[i][COORD_BITS] ? {1'b0, neg[i][COORD_BITS-1:0]}
			                              : {1'b0, delta[i][COORD_BITS-1:0]};
			if (mag[i] > ext[i]) begin
				gap_d[i] = COORD_BITS'(mag[i] - ext[i]);
			end else begin
				gap_d[i] = '0;
			end
		end
	end

	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctl_s2    <= in_ctl;
			gap_s2    <= gap_d;
			radius_s2 <= in_radius;
		end
	end

	assign out_valid  = v_s2;
	assign out_ctl    = ctl_s2;
	assign gap        = gap_s2;
	assign out_radius = radius_s2;

endmodule

### rtl/cpot_square.sv
module cpot_square #(
	parameter int COORD_BITS = cpot_pkg::CoordBitsDef
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  cpot_pkg::ctl_t                                in_ctl,
	input  logic [cpot_pkg::Lanes-1:0][COORD_BITS-1:0]    gap,
	input  logic [COORD_BITS:0]                           radius,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output cpot_pkg::ctl_t                                out_ctl,
	output logic [cpot_pkg::Lanes-1:0][2*COORD_BITS-1:0]  sq,
	output logic [2*COORD_BITS+1:0]                       r2
);

	localparam int SqW = 2 * COORD_BITS;
	localparam int R2W = 2 * COORD_BITS + 2;

	logic [cpot_pkg::Lanes-1:0][SqW-1:0]  sq_d;
	logic [R2W-1:0]                       r2_d;

	logic                                 v_s3;
	cpot_pkg::ctl_t                       ctl_s3;
	logic [cpot_pkg::Lanes-1:0][SqW-1:0]  sq_s3;
	logic [R2W-1:0]                       r2_s3;

	always_comb begin
		for (int i = 0; i < cpot_pkg::Lanes; i++) begin
			sq_d[i] = SqW'(gap[i]) * SqW'(gap[i]);
		end
		r2_d = R2W'(radius) * R2W'(radius);
	end

	assign in_ready = !v_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctl_s3 <= in_ctl;
			sq_s3  <= sq_d;
			r2_s3  <= r2_d;
		end
	end

	assign out_valid = v_s3;
	assign out_ctl   = ctl_s3;
	assign sq        = sq_s3;
	assign r2        = r2_s3;

endmodule

### rtl/cpot_decide.sv
module cpot_decide #(
	parameter int COORD_BITS = cpot_pkg::CoordBitsDef
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  cpot_pkg::ctl_t                                in_ctl,
	input  logic [cpot_pkg::Lanes-1:0][2*COORD_BITS-1:0]  sq,
	input  logic [2*COORD_BITS+1:0]                       r2,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic                                          overlap,
	output logic                                          filter_pass
);

	localparam int SumW = 2 * COORD_BITS + 2;

	logic [SumW-1:0]  sum_d;
	logic             hit_d;

	logic             v_s4;
	logic             overlap_s4;
	logic             pass_s4;

	// box pairs touch only when every axis gap is zero
	always_comb begin
		sum_d = SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);
		if (in_ctl.box_box) begin
			hit_d = (sum_d == '0);
		end else begin
			hit_d = (sum_d <= r2);
		end
	end

	assign in_ready = !v_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			overlap_s4 <= in_ctl.pass && hit_d;
			pass_s4    <= in_ctl.pass;
		end
	end

	assign out_valid   = v_s4;
	assign overlap     = overlap_s4;
	assign filter_pass = pass_s4;

endmodule

### rtl/collider_pair_overlap_test_unit.sv
// collider pair overlap test unit
// pair channel (sink): one beat carries two colliders, each a sphere or an
//   axis-aligned box with packed x/y/z center and extent lanes, a layer word
//   and a mask word
// result channel (source): one beat per pair with overlap and filter_pass;
//   overlap is never set for a pair that the layer/mask filter rejects
// stages: one register stage each for shape select and filter, axis clamp,
//   squaring, and the sum and compare that also serves as the output
//   register
// throughput: one pair per cycle while result.ready is high, set by the
//   four-stage valid/ready pipeline
// reset: arst_n clears all stage valid bits at once, so the unit comes out
//   of reset empty and ready; the stage data registers are not reset
// stall: while result.ready is low a held result stays put and each stage
//   keeps its beat once the stage after it is full; pair.ready drops only
//   when all four stages hold a beat, and nothing is lost or repeated
`include "collider_pair_overlap_test_unit_macros.svh"

module collider_pair_overlap_test_unit #(
	parameter int COORD_BITS = cpot_pkg::CoordBitsDef,
	parameter int LAYER_BITS = cpot_pkg::LayerBitsDef
) (
	input  logic            clk,
	input  logic            arst_n,
	cpot_pair_if.sink       pair,
	cpot_result_if.source   result
);

	localparam int Lanes = cpot_pkg::Lanes;

	// stage one: shape selection, lane unpack, layer/mask filter
	logic                                v_s1, rdy_s1;
	cpot_pkg::ctl_t                      ctl_s1;
	logic [Lanes-1:0][COORD_BITS:0]      delta_s1, ext_s1;
	logic [COORD_BITS:0]                 r_s1;

	// stage two: per-axis distance outside the box
	logic                                v_s2, rdy_s2;
	cpot_pkg::ctl_t                      ctl_s2;
	logic [Lanes-1:0][COORD_BITS-1:0]    gap_s2;
	logic [COORD_BITS:0]                 r_s2;

	// stage three: squares
	logic                                v_s3, rdy_s3;
	cpot_pkg::ctl_t                      ctl_s3;
	logic [Lanes-1:0][2*COORD_BITS-1:0]  sq_s3;
	logic [2*COORD_BITS+1:0]             r2_s3;

	cpot_prep #(
		.COORD_BITS (COORD_BITS),
		.LAYER_BITS (LAYER_BITS)
	) u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (pair.valid),
		.in_ready      (pair.ready),
		.first_shape   (pair.first_shape),
		.first_center  (pair.first_center),
		.first_extent  (pair.first_extent),
		.first_layer   (pair.first_layer),
		.first_mask    (pair.first_mask),
		.second_shape  (pair.second_shape),
		.second_center (pair.second_center),
		.second_extent (pair.second_extent),
		.second_layer  (pair.second_layer),
		.second_mask   (pair.second_mask),
		.out_valid     (v_s1),
		.out_ready     (rdy_s1),
		.ctl           (ctl_s1),
		.delta         (delta_s1),
		.ext           (ext_s1),
		.radius        (r_s1)
	);

	cpot_clamp #(
		.COORD_BITS (COORD_BITS)
	) u_clamp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s1),
		.in_ready   (rdy_s1),
		.in_ctl     (ctl_s1),
		.delta      (delta_s1),
		.ext        (ext_s1),
		.in_radius  (r_s1),
		.out_valid  (v_s2),
		.out_ready  (rdy_s2),
		.out_ctl    (ctl_s2),
		.gap        (gap_s2),
		.out_radius (r_s2)
	);

	cpot_square #(
		.COORD_BITS (COORD_BITS)
	) u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (rdy_s2),
		.in_ctl    (ctl_s2),
		.gap       (gap_s2),
		.radius    (r_s2),
		.out_valid (v_s3),
		.out_ready (rdy_s3),
		.out_ctl   (ctl_s3),
		.sq        (sq_s3),
		.r2        (r2_s3)
	);

	// final stage doubles as the output register
	cpot_decide #(
		.COORD_BITS (COORD_BITS)
	) u_decide (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s3),
		.in_ready    (rdy_s3),
		.in_ctl      (ctl_s3),
		.sq          (sq_s3),
		.r2          (r2_s3),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.overlap     (result.overlap),
		.filter_pass (result.filter_pass)
	);

	// an empty output stage means every stage can take a beat
	`CPOT_ASSERT_IMPL(a_ready_when_out_empty, !result.valid, pair.ready)
	// a rejected pair never reports a hit
	`CPOT_ASSERT_IMPL(a_overlap_needs_pass, result.valid, !result.overlap || result.filter_pass)
	// box pairs carry no radius into the pipe
	`CPOT_ASSERT_IMPL(a_box_pair_no_radius, v_s1 && ctl_s1.box_box, r_s1 == '0)
	// an accepted pair lands in stage one
	`CPOT_ASSERT_NEXT(a_accept_fills_s1, pair.valid && pair.ready, v_s1)

endmodule
